/* design/urd_pkg.sv */
// ----------------------------------------------------------------------------
// urd_pkg
// Types, constants and lookup functions shared by the range display modules.
// ----------------------------------------------------------------------------
package urd_pkg;

  // Payload of one input item.
  typedef struct packed {
    logic        kind;
    logic        echo_seen;
    logic [15:0] echo_count;
  } in_item_t;

  // Payload of one result item.
  typedef struct packed {
    logic [10:0] distance;
    logic [3:0]  level;
    logic [7:0]  bar_pattern;
    logic [1:0]  bar_extra;
    logic [7:0]  seg_ones;
    logic [7:0]  seg_tens;
    logic [7:0]  seg_hundreds;
    logic        beeper_pin;
  } out_item_t;

  // Item held between the front stage and the state update.
  typedef struct packed {
    logic        kind;
    logic [10:0] dist_cm;
  } meas_t;

  // Architectural state of the display and beeper.
  typedef struct packed {
    logic [10:0] dist_cm;
    logic [3:0]  level;
    logic [4:0]  period;
    logic [4:0]  count;
    logic        beeper;
  } disp_state_t;

  // Result of grading a distance.
  typedef struct packed {
    logic [3:0] level;
    logic [4:0] period;
    logic       load_period;
  } grade_t;

  localparam logic KIND_MEAS = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Echo count / 59 as (count * 35545) >> 21, exact over 16-bit counts.
  localparam logic [31:0] DIST_RECIP   = 32'd35545;
  localparam int          DIST_SHIFT   = 21;
  localparam logic [10:0] NO_ECHO_DIST = 11'd888;
  localparam logic [10:0] RESET_DIST   = 11'd95;

  // Decimal split of an 11-bit distance by reciprocal multiplication.
  localparam logic [21:0] DIV10_RECIP   = 22'd1639;
  localparam int          DIV10_SHIFT   = 14;
  localparam logic [21:0] DIV100_RECIP  = 22'd1311;
  localparam int          DIV100_SHIFT  = 17;

  localparam logic [3:0] LEVEL_FAR  = 4'd0;
  localparam logic [3:0] LEVEL_NEAR = 4'd10;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'h14;
      4'd1:    code = 8'h77;
      4'd2:    code = 8'h4c;
      4'd3:    code = 8'h45;
      4'd4:    code = 8'h27;
      4'd5:    code = 8'h85;
      4'd6:    code = 8'h84;
      4'd7:    code = 8'h57;
      4'd8:    code = 8'h04;
      4'd9:    code = 8'h05;
      default: code = 8'hff;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] bar_main(input logic [3:0] level);
    logic [7:0] pattern;
    case (level)
      4'd0, 4'd1, 4'd2: pattern = 8'hff;
      4'd3:    pattern = 8'h7f;
      4'd4:    pattern = 8'h3f;
      4'd5:    pattern = 8'h1f;
      4'd6:    pattern = 8'h0f;
      4'd7:    pattern = 8'h07;
      4'd8:    pattern = 8'h03;
      4'd9:    pattern = 8'h01;
      default: pattern = 8'h00;
    endcase
    return pattern;
  endfunction

  function automatic logic [1:0] bar_ext(input logic [3:0] level);
    logic [1:0] leds;
    case (level)
      4'd0:    leds = 2'd3;
      4'd1:    leds = 2'd2;
      default: leds = 2'd0;
    endcase
    return leds;
  endfunction

  // Threshold ladder: the first bound the distance lies above (at or above for 100) sets the level.
  function automatic grade_t grade(input logic [10:0] dist_cm);
    grade_t g;
    g.load_period = 1'b1;
    g.period      = 5'd0;
    if (dist_cm >= 11'd100) begin
      g.level       = LEVEL_FAR;
      g.load_period = 1'b0;
    end else if (dist_cm > 11'd90) begin
      g.level = 4'd1; g.period = 5'd25;
    end else if (dist_cm > 11'd85) begin
      g.level = 4'd2; g.period = 5'd15;
    end else if (dist_cm > 11'd80) begin
      g.level = 4'd3; g.period = 5'd9;
    end else if (dist_cm > 11'd75) begin
      g.level = 4'd4; g.period = 5'd7;
    end else if (dist_cm > 11'd70) begin
      g.level = 4'd5; g.period = 5'd5;
    end else if (dist_cm > 11'd65) begin
      g.level = 4'd6; g.period = 5'd4;
    end else if (dist_cm > 11'd60) begin
      g.level = 4'd7; g.period = 5'd3;
    end else if (dist_cm > 11'd55) begin
      g.level = 4'd8; g.period = 5'd2;
    end else if (dist_cm > 11'd50) begin
      g.level = 4'd9; g.period = 5'd1;
    end else begin
      g.level       = LEVEL_NEAR;
      g.load_period = 1'b0;
    end
    return g;
  endfunction

endpackage

/* design/urd_front.sv */
// ----------------------------------------------------------------------------
// urd_front
// Input register: takes an item and turns the echo count into centimetres.
// ----------------------------------------------------------------------------
module urd_front import urd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     advance,
  output logic     meas_valid,
  output meas_t    meas
);

  logic [31:0] prod;
  meas_t       meas_next;
  logic        load;

  assign in_stall = meas_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    prod           = {16'd0, in_item.echo_count} * DIST_RECIP;
    meas_next.kind = in_item.kind;
    if (in_item.echo_seen) begin
      meas_next.dist_cm = 11'(prod >> DIST_SHIFT);
    end else begin
      meas_next.dist_cm = NO_ECHO_DIST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meas_valid <= 1'b0;
    end else if (load) begin
      meas_valid <= 1'b1;
    end else if (advance) begin
      meas_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      meas <= meas_next;
    end
  end

endmodule

/* design/urd_state.sv */
// ----------------------------------------------------------------------------
// urd_state
// Distance, bar level and beeper state, updated once for every item.
// ----------------------------------------------------------------------------
module urd_state import urd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  meas_t       meas,
  output disp_state_t state_next
);

  disp_state_t state;
  grade_t      g;
  logic [4:0]  count_inc;

  always_comb begin
    g          = grade(meas.dist_cm);
    count_inc  = state.count + 5'd1;
    state_next = state;
    if (meas.kind == KIND_MEAS) begin
      state_next.dist_cm = meas.dist_cm;
      state_next.level   = g.level;
      if (g.load_period) begin
        state_next.period = g.period;
      end
    end else if (state.level == LEVEL_FAR) begin
      state_next.beeper = 1'b1;
    end else if (state.level >= LEVEL_NEAR) begin
      state_next.beeper = 1'b0;
    end else if (count_inc > state.period) begin
      state_next.count  = 5'd0;
      state_next.beeper = !state.beeper;
    end else begin
      state_next.count = count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.dist_cm <= RESET_DIST;
      state.level   <= LEVEL_FAR;
      state.period  <= 5'd0;
      state.count   <= 5'd0;
      state.beeper  <= 1'b1;
    end else if (fire) begin
      state <= state_next;
    end
  end

endmodule

/* design/urd_out.sv */
// ----------------------------------------------------------------------------
// urd_out
// Result register: bar pattern, digit codes and beeper for the new state.
// ----------------------------------------------------------------------------
module urd_out import urd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  disp_state_t state_next,
  output logic        advance,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item
);

  logic [21:0] prod10;
  logic [21:0] prod100;
  logic [7:0]  tens_q;
  logic [4:0]  hund_q;
  logic [10:0] ones_w;
  logic [7:0]  tens_w;
  logic [4:0]  hund_w;
  out_item_t   item_next;

  assign advance = !out_valid || !out_stall;

  // Both quotients come straight from the distance so that they run side by side.
  always_comb begin
    prod10  = {11'd0, state_next.dist_cm} * DIV10_RECIP;
    prod100 = {11'd0, state_next.dist_cm} * DIV100_RECIP;
    tens_q  = 8'(prod10 >> DIV10_SHIFT);
    hund_q  = 5'(prod100 >> DIV100_SHIFT);
    ones_w  = state_next.dist_cm - 11'({tens_q, 3'd0} + {2'd0, tens_q, 1'd0});
    tens_w  = tens_q - 8'({hund_q, 3'd0} + {2'd0, hund_q, 1'd0});
    hund_w  = (hund_q >= 5'd10) ? hund_q - 5'd10 : hund_q;

    item_next.distance     = state_next.dist_cm;
    item_next.level        = state_next.level;
    item_next.bar_pattern  = bar_main(state_next.level);
    item_next.bar_extra    = bar_ext(state_next.level);
    item_next.seg_ones     = seg_code(ones_w[3:0]);
    item_next.seg_tens     = seg_code(tens_w[3:0]);
    item_next.seg_hundreds = seg_code(hund_w[3:0]);
    item_next.beeper_pin   = state_next.beeper;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= item_next;
    end
  end

endmodule

/* design/ultrasonic_range_display_top.sv */
// ----------------------------------------------------------------------------
// ultrasonic_range_display_top
// Ultrasonic range display: distance, LED bar, digit codes and beeper drive.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_stall    in_item  (kind, echo_seen, echo_count)
//  result    out_valid / out_stall  out_item (distance .. beeper_pin)
//
//  One item per cycle is taken while no stall holds the flow, and one result per item is given.
//  A result passes through the input register (echo count to centimetres)
//  and then through the state update and result register.
//  Reset clears both stage valids and loads distance 95, level 0, beeper on.
//  A stalled result holds; the input register still takes one more item.
// ----------------------------------------------------------------------------
module ultrasonic_range_display_top import urd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic        advance;
  logic        meas_valid;
  meas_t       meas;
  logic        fire;
  disp_state_t state_next;

  assign fire = meas_valid && advance;

  urd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .meas_valid (meas_valid),
    .meas       (meas)
  );

  urd_state u_state (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .meas       (meas),
    .state_next (state_next)
  );

  urd_out u_out (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .state_next (state_next),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule
